// ===== rtl/grid_min_path_sum_traceback_assert.svh =====
// Assertion macros shared by the grid minimum path sum RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef GRID_MIN_PATH_SUM_TRACEBACK_ASSERT_SVH
`define GRID_MIN_PATH_SUM_TRACEBACK_ASSERT_SVH

// Same-cycle implication.
`define GMPS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GMPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gmps_pkg.sv =====
// Package for the grid minimum path sum block: widths, codes, types, helpers.
// No dependencies.
package gmps_pkg;

    localparam int MAX_COLS_DEF = 16;
    localparam int MAX_ROWS_DEF = 16;

    localparam int COST_W    = 8;
    localparam int SUM_W     = 13;
    localparam int POS_W     = 4;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [SUM_W-1:0]     SUM_MAX       = 13'h1FFF;
    localparam logic [CFG_W-1:0]     GRID_RESET    = 5'd16;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd1;

    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_LEFT,
        SEL_UP,
        SEL_MIN
    } sel_t;

    typedef struct packed {
        sel_t              mode;
        logic [COST_W-1:0] addend;
    } alu_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_TB_EMIT,
        ST_TB_WAIT
    } state_t;

    function automatic logic [6:0] clamp_size(input logic [CFG_W-1:0] v, input int maxv);
        logic [6:0] res;
        if (v == '0)
            res = 7'd1;
        else if (int'(v) > maxv)
            res = 7'(maxv);
        else
            res = 7'(v);
        return res;
    endfunction

endpackage

// ===== rtl/gmps_if.sv =====
// Valid/ready channel interfaces for cell costs in and path words out.
// Depends on gmps_pkg.
interface gmps_cell_if;
    logic                        valid;
    logic                        ready;
    logic [gmps_pkg::COST_W-1:0] cell_cost;

    modport source (output valid, output cell_cost, input ready);
    modport sink   (input valid, input cell_cost, output ready);
endinterface

interface gmps_path_if;
    logic                       valid;
    logic                       ready;
    logic [gmps_pkg::POS_W-1:0] path_row;
    logic [gmps_pkg::POS_W-1:0] path_col;
    logic [gmps_pkg::SUM_W-1:0] path_sum;
    logic                       last_step;

    modport source (output valid, output path_row, output path_col, output path_sum,
                    output last_step, input ready);
    modport sink   (input valid, input path_row, input path_col, input path_sum,
                    input last_step, output ready);
endinterface

// ===== rtl/grid_min_path_sum_traceback.sv =====
// Each cell cost is handled as a registered read of the left and upper sums from the
// table, then a pass through the shared select-add unit and a table write. After the
// last cell the block is busy with the traceback: rows+cols-1 words; each but the origin
// word is emitted and then followed by a read of the two neighbor sums, and the origin
// word ends the traceback. The table needs no clearing after reset. Writing a size
// register restarts loading at cell zero, except during a cell step, which still advances.
// Depends on gmps_pkg, gmps_if, gmps_sum_ram, gmps_alu and the assertion macro header.
`include "grid_min_path_sum_traceback_assert.svh"

module grid_min_path_sum_traceback #(
    parameter int MAX_COLS = gmps_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = gmps_pkg::MAX_ROWS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [gmps_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmps_pkg::CFG_W-1:0]     cfg_wdata,
    gmps_cell_if.sink                      cell_chan,
    gmps_path_if.source                    path_chan
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);

    gmps_pkg::state_t state_reg, state_next;

    logic [gmps_pkg::CFG_W-1:0] cols_reg, cols_next;
    logic [gmps_pkg::CFG_W-1:0] rows_reg, rows_next;

    logic [ADDR_W-1:0] ld_idx_reg, ld_idx_next;
    logic [COL_W-1:0]  ld_col_reg, ld_col_next;
    logic [ROW_W-1:0]  ld_row_reg, ld_row_next;

    logic [gmps_pkg::COST_W-1:0] cost_reg, cost_next;

    logic [ADDR_W-1:0]          tb_idx_reg, tb_idx_next;
    logic [COL_W-1:0]           tb_col_reg, tb_col_next;
    logic [ROW_W-1:0]           tb_row_reg, tb_row_next;
    logic [gmps_pkg::SUM_W-1:0] tb_sum_reg, tb_sum_next;

    logic                       out_valid_reg, out_valid_next;
    logic [gmps_pkg::POS_W-1:0] out_row_reg, out_row_next;
    logic [gmps_pkg::POS_W-1:0] out_col_reg, out_col_next;
    logic [gmps_pkg::SUM_W-1:0] out_sum_reg, out_sum_next;
    logic                       out_last_reg, out_last_next;

    logic [CCNT_W-1:0] cols_eff;
    logic [RCNT_W-1:0] rows_eff;
    logic [COL_W-1:0]  cols_m1;
    logic [ROW_W-1:0]  rows_m1;
    logic              last_cell;

    logic [ADDR_W-1:0] rd_base;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;

    logic                       wr_en;
    logic [gmps_pkg::SUM_W-1:0] left_sum;
    logic [gmps_pkg::SUM_W-1:0] up_sum;
    gmps_pkg::alu_req_t         alu_req;
    logic [gmps_pkg::SUM_W-1:0] alu_result;
    logic                       take_left;
    logic                       out_free;
    logic                       at_origin;

    assign cols_eff  = CCNT_W'(gmps_pkg::clamp_size(cols_reg, MAX_COLS));
    assign rows_eff  = RCNT_W'(gmps_pkg::clamp_size(rows_reg, MAX_ROWS));
    assign cols_m1   = COL_W'(cols_eff - 1'b1);
    assign rows_m1   = ROW_W'(rows_eff - 1'b1);
    assign last_cell = (ld_row_reg == rows_m1) && (ld_col_reg == cols_m1);

    assign rd_base   = (state_reg == gmps_pkg::ST_IDLE) ? ld_idx_reg : tb_idx_reg;
    assign rd_addr_a = rd_base - 1'b1;
    assign rd_addr_b = rd_base - ADDR_W'(cols_eff);

    assign pos_col   = (state_reg == gmps_pkg::ST_CELL) ? ld_col_reg : tb_col_reg;
    assign pos_row   = (state_reg == gmps_pkg::ST_CELL) ? ld_row_reg : tb_row_reg;
    assign at_origin = (tb_row_reg == '0) && (tb_col_reg == '0);
    assign out_free  = !out_valid_reg || path_chan.ready;
    assign wr_en     = (state_reg == gmps_pkg::ST_CELL);

    always_comb
    begin
        if (pos_row == '0 && pos_col == '0)
            alu_req.mode = gmps_pkg::SEL_NONE;
        else if (pos_row == '0)
            alu_req.mode = gmps_pkg::SEL_LEFT;
        else if (pos_col == '0)
            alu_req.mode = gmps_pkg::SEL_UP;
        else
            alu_req.mode = gmps_pkg::SEL_MIN;
        alu_req.addend = (state_reg == gmps_pkg::ST_CELL) ? cost_reg : '0;
    end

    gmps_sum_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (ld_idx_reg),
        .wr_data   (alu_result),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (left_sum),
        .rd_data_b (up_sum)
    );

    gmps_alu u_alu (
        .req       (alu_req),
        .left_sum  (left_sum),
        .up_sum    (up_sum),
        .result    (alu_result),
        .take_left (take_left)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmps_pkg::ST_IDLE;
            cols_reg      <= gmps_pkg::GRID_RESET;
            rows_reg      <= gmps_pkg::GRID_RESET;
            ld_idx_reg    <= '0;
            ld_col_reg    <= '0;
            ld_row_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            ld_idx_reg    <= ld_idx_next;
            ld_col_reg    <= ld_col_next;
            ld_row_reg    <= ld_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cost_reg     <= cost_next;
        tb_idx_reg   <= tb_idx_next;
        tb_col_reg   <= tb_col_next;
        tb_row_reg   <= tb_row_next;
        tb_sum_reg   <= tb_sum_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_sum_reg  <= out_sum_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        ld_idx_next    = ld_idx_reg;
        ld_col_next    = ld_col_reg;
        ld_row_next    = ld_row_reg;
        cost_next      = cost_reg;
        tb_idx_next    = tb_idx_reg;
        tb_col_next    = tb_col_reg;
        tb_row_next    = tb_row_reg;
        tb_sum_next    = tb_sum_reg;
        out_valid_next = out_valid_reg && !path_chan.ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_sum_next   = out_sum_reg;
        out_last_next  = out_last_reg;

        if (cfg_we)
        begin
            if (cfg_index == gmps_pkg::CFG_GRID_COLS)
            begin
                cols_next   = cfg_wdata;
                ld_idx_next = '0;
                ld_col_next = '0;
                ld_row_next = '0;
            end
            else if (cfg_index == gmps_pkg::CFG_GRID_ROWS)
            begin
                rows_next   = cfg_wdata;
                ld_idx_next = '0;
                ld_col_next = '0;
                ld_row_next = '0;
            end
        end

        case (state_reg)
            gmps_pkg::ST_IDLE:
            begin
                if (cell_chan.valid)
                begin
                    cost_next  = cell_chan.cell_cost;
                    state_next = gmps_pkg::ST_CELL;
                end
            end
            gmps_pkg::ST_CELL:
            begin
                if (last_cell)
                begin
                    tb_idx_next = ld_idx_reg;
                    tb_col_next = ld_col_reg;
                    tb_row_next = ld_row_reg;
                    tb_sum_next = alu_result;
                    ld_idx_next = '0;
                    ld_col_next = '0;
                    ld_row_next = '0;
                    state_next  = gmps_pkg::ST_TB_EMIT;
                end
                else
                begin
                    ld_idx_next = ld_idx_reg + 1'b1;
                    if (ld_col_reg == cols_m1)
                    begin
                        ld_col_next = '0;
                        ld_row_next = ld_row_reg + 1'b1;
                    end
                    else
                    begin
                        ld_col_next = ld_col_reg + 1'b1;
                    end
                    state_next = gmps_pkg::ST_IDLE;
                end
            end
            gmps_pkg::ST_TB_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = gmps_pkg::POS_W'(tb_row_reg);
                    out_col_next   = gmps_pkg::POS_W'(tb_col_reg);
                    out_sum_next   = tb_sum_reg;
                    out_last_next  = at_origin;
                    state_next     = at_origin ? gmps_pkg::ST_IDLE : gmps_pkg::ST_TB_WAIT;
                end
            end
            gmps_pkg::ST_TB_WAIT:
            begin
                tb_sum_next = alu_result;
                if (take_left)
                begin
                    tb_col_next = tb_col_reg - 1'b1;
                    tb_idx_next = tb_idx_reg - 1'b1;
                end
                else
                begin
                    tb_row_next = tb_row_reg - 1'b1;
                    tb_idx_next = tb_idx_reg - ADDR_W'(cols_eff);
                end
                state_next = gmps_pkg::ST_TB_EMIT;
            end
            default:
            begin
                state_next = gmps_pkg::ST_IDLE;
            end
        endcase
    end

    assign cell_chan.ready     = (state_reg == gmps_pkg::ST_IDLE);
    assign path_chan.valid     = out_valid_reg;
    assign path_chan.path_row  = out_row_reg;
    assign path_chan.path_col  = out_col_reg;
    assign path_chan.path_sum  = out_sum_reg;
    assign path_chan.last_step = out_last_reg;

    `GMPS_ASSERT_NEXT(a_accept_to_cell, cell_chan.valid && cell_chan.ready, state_reg == gmps_pkg::ST_CELL, "accepted word did not enter cell step")
    `GMPS_ASSERT_IMPL(a_last_at_origin, path_chan.valid && path_chan.last_step, path_chan.path_row == '0 && path_chan.path_col == '0, "last word not at origin")
    `GMPS_ASSERT_NEXT(a_wait_to_emit, state_reg == gmps_pkg::ST_TB_WAIT, state_reg == gmps_pkg::ST_TB_EMIT, "traceback step did not return to emit")

endmodule

// ===== rtl/gmps_sum_ram.sv =====
// Best-sum table: one write port, two registered read ports.
// Depends on gmps_pkg.
module gmps_sum_ram #(
    parameter int DEPTH  = gmps_pkg::MAX_ROWS_DEF * gmps_pkg::MAX_COLS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [gmps_pkg::SUM_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr_a,
    input  logic [ADDR_W-1:0]          rd_addr_b,
    output logic [gmps_pkg::SUM_W-1:0] rd_data_a,
    output logic [gmps_pkg::SUM_W-1:0] rd_data_b
);

    logic [gmps_pkg::SUM_W-1:0] mem [0:DEPTH-1];
    logic [gmps_pkg::SUM_W-1:0] rd_data_a_reg;
    logic [gmps_pkg::SUM_W-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_a_reg <= mem[rd_addr_a];
        rd_data_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== rtl/gmps_alu.sv =====
// Shared select-and-add unit: picks a neighbor sum and adds a cost with saturation.
// Depends on gmps_pkg.
module gmps_alu (
    input  gmps_pkg::alu_req_t         req,
    input  logic [gmps_pkg::SUM_W-1:0] left_sum,
    input  logic [gmps_pkg::SUM_W-1:0] up_sum,
    output logic [gmps_pkg::SUM_W-1:0] result,
    output logic                       take_left
);

    logic [gmps_pkg::SUM_W-1:0] chosen;
    logic [gmps_pkg::SUM_W:0]   wide;

    always_comb
    begin
        case (req.mode)
            gmps_pkg::SEL_NONE: take_left = 1'b0;
            gmps_pkg::SEL_LEFT: take_left = 1'b1;
            gmps_pkg::SEL_UP:   take_left = 1'b0;
            gmps_pkg::SEL_MIN:  take_left = (left_sum <= up_sum);
            default:            take_left = 1'b0;
        endcase

        if (req.mode == gmps_pkg::SEL_NONE)
            chosen = '0;
        else if (take_left)
            chosen = left_sum;
        else
            chosen = up_sum;

        wide = {1'b0, chosen} + (gmps_pkg::SUM_W + 1)'(req.addend);
        result = wide[gmps_pkg::SUM_W] ? gmps_pkg::SUM_MAX : wide[gmps_pkg::SUM_W-1:0];
    end

endmodule
